/* src/cfc_pkg.sv */
// ----------------------------------------------------------------------------
// cfc_pkg
// shared types and constants of the command frame checker
// ----------------------------------------------------------------------------
package cfc_pkg;

  localparam int unsigned FRAME_CELLS = 7;

  localparam logic [7:0] FRAME_HEAD     = 8'hAA;
  localparam logic [7:0] FRAME_TAIL     = 8'h55;
  localparam logic [8:0] PAIR_SUM       = 9'h0FF;
  localparam logic [7:0] SLOT_MAX       = 8'h3C;
  localparam logic [7:0] CMD_TEMP_CODE  = 8'hDC;
  localparam logic [7:0] CMD_SET_TEMP   = 8'hCF;
  localparam logic [7:0] CMD_DEFROST    = 8'hD1;
  localparam logic [7:0] CMD_WORK       = 8'hD2;
  localparam logic [7:0] CMD_REST       = 8'hD3;
  localparam logic [7:0] CMD_LED        = 8'hDD;
  localparam logic [7:0] SETPOINT_RESET = 8'd20;
  localparam logic [2:0] LAST_INDEX     = 3'd7;

  typedef enum logic [3:0] {
    ST_BAD       = 4'd0,
    ST_SLOT      = 4'd1,
    ST_TEMP_CODE = 4'd2,
    ST_SET_TEMP  = 4'd3,
    ST_DEFROST   = 4'd4,
    ST_WORK      = 4'd5,
    ST_REST      = 4'd6,
    ST_LED       = 4'd7,
    ST_UNKNOWN   = 4'd8
  } status_e;

  typedef enum logic [1:0] {
    ACT_NONE = 2'd0,
    ACT_ON   = 2'd1,
    ACT_OFF  = 2'd2
  } action_e;

  typedef struct packed {
    logic take;
    logic frame_end;
  } ctl_t;

  typedef logic [FRAME_CELLS-1:0][7:0] cells_t;

endpackage

/* src/cfc_if.sv */
// ----------------------------------------------------------------------------
// cfc_if
// byte request and result channels of the command frame checker
// ----------------------------------------------------------------------------
interface cfc_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface cfc_result_if;
  logic       valid;
  logic       ready;
  logic [3:0] status;
  logic [7:0] value;
  logic       value_nonzero;
  logic [7:0] setpoint;
  logic [1:0] cooler_action;

  modport source (
    output valid, output status, output value, output value_nonzero,
    output setpoint, output cooler_action, input ready
  );
  modport sink (
    input valid, input status, input value, input value_nonzero,
    input setpoint, input cooler_action, output ready
  );
endinterface

/* src/command_frame_checker_unit.sv */
// a result appears in the cycle after the request carrying the eighth byte
// throughput: one byte request per cycle while the result side keeps up
// a waiting result holds off new bytes only when the result side stalls
// the byte position is a 3-bit counter; bytes 0..6 sit in a chain of seven cells
// reset: asynchronous active low; count cleared, no result pending, setpoint 20
// ----------------------------------------------------------------------------
// command_frame_checker_unit
// collects 8-byte command frames, checks them and reports one result per frame
// ----------------------------------------------------------------------------
module command_frame_checker_unit (
  input  logic   clk_i,
  input  logic   rst_ni,
  cfc_byte_if.sink     rx_i,
  cfc_result_if.source res_o
);
  import cfc_pkg::*;

  logic [2:0]     idx_q, idx_d;
  ctl_t           ctl;
  cells_t         cells;
  logic           res_valid;
  status_e        status;
  action_e        action;

  assign rx_i.ready    = !res_valid || res_o.ready;
  assign ctl.take      = rx_i.valid && rx_i.ready;
  assign ctl.frame_end = (idx_q == LAST_INDEX);

  always_comb begin
    idx_d = idx_q;
    if (ctl.take) begin
      idx_d = idx_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= 3'd0;
    end else begin
      idx_q <= idx_d;
    end
  end

  for (genvar k = 0; k < FRAME_CELLS; k++) begin : g_cell
    if (k == 0) begin : g_head
      cfc_cell u_cell (
        .clk_i   (clk_i),
        .shift_i (ctl.take),
        .d_i     (rx_i.rx_byte),
        .q_o     (cells[k])
      );
    end else begin : g_body
      cfc_cell u_cell (
        .clk_i   (clk_i),
        .shift_i (ctl.take),
        .d_i     (cells[k-1]),
        .q_o     (cells[k])
      );
    end
  end

  cfc_classifier u_classifier (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .ctl_i           (ctl),
    .cells_i         (cells),
    .last_byte_i     (rx_i.rx_byte),
    .res_ready_i     (res_o.ready),
    .res_valid_o     (res_valid),
    .status_o        (status),
    .value_o         (res_o.value),
    .value_nonzero_o (res_o.value_nonzero),
    .setpoint_o      (res_o.setpoint),
    .action_o        (action)
  );

  assign res_o.valid         = res_valid;
  assign res_o.status        = status;
  assign res_o.cooler_action = action;

  a_result_after_eighth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(res_valid) |-> $past(ctl.take) && ($past(idx_q) == LAST_INDEX) && (idx_q == 3'd0))
    else $error("result raised without a completed frame");

  a_count_advances: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.take |=> (idx_q == $past(idx_q) + 3'd1))
    else $error("byte position did not advance on a request");

  a_count_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !ctl.take |=> $stable(idx_q))
    else $error("byte position moved without a request");

endmodule

/* src/cfc_cell.sv */
// ----------------------------------------------------------------------------
// cfc_cell
// one byte cell of the frame shift chain
// ----------------------------------------------------------------------------
module cfc_cell (
  input  logic       clk_i,
  input  logic       shift_i,
  input  logic [7:0] d_i,
  output logic [7:0] q_o
);

  logic [7:0] byte_q;

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      byte_q <= d_i;
    end
  end

  assign q_o = byte_q;

endmodule

/* src/cfc_classifier.sv */
// ----------------------------------------------------------------------------
// cfc_classifier
// frame check, command decode, setpoint register and result register
// ----------------------------------------------------------------------------
module cfc_classifier (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cfc_pkg::ctl_t       ctl_i,
  input  cfc_pkg::cells_t     cells_i,
  input  logic [7:0]          last_byte_i,
  input  logic                res_ready_i,
  output logic                res_valid_o,
  output cfc_pkg::status_e    status_o,
  output logic [7:0]          value_o,
  output logic                value_nonzero_o,
  output logic [7:0]          setpoint_o,
  output cfc_pkg::action_e    action_o
);
  import cfc_pkg::*;

  logic       valid_q;
  status_e    status_q, status_d;
  logic [7:0] value_q, value_d;
  logic       nonzero_q;
  logic [7:0] setpoint_q, setpoint_d;
  action_e    action_q, action_d;
  logic       frame_ok;
  logic [7:0] cmd, arg;
  logic       fire;

  // oldest byte sits in the far end of the chain
  assign cmd  = cells_i[3];
  assign arg  = cells_i[1];
  assign fire = ctl_i.take && ctl_i.frame_end;

  assign frame_ok = (cells_i[6] == FRAME_HEAD) && (last_byte_i == FRAME_TAIL)
    && (({1'b0, cells_i[5]} + {1'b0, cells_i[4]}) == PAIR_SUM)
    && (({1'b0, cells_i[3]} + {1'b0, cells_i[2]}) == PAIR_SUM)
    && (({1'b0, cells_i[1]} + {1'b0, cells_i[0]}) == PAIR_SUM);

  always_comb begin
    status_d   = ST_BAD;
    value_d    = 8'd0;
    action_d   = ACT_NONE;
    setpoint_d = setpoint_q;
    if (frame_ok) begin
      value_d = arg;
      if ((cmd != 8'd0) && (cmd <= SLOT_MAX)) begin
        status_d = ST_SLOT;
        value_d  = cmd;
      end else if (cmd == CMD_TEMP_CODE) begin
        status_d = ST_TEMP_CODE;
      end else if (cmd == CMD_SET_TEMP) begin
        status_d   = ST_SET_TEMP;
        setpoint_d = arg;
        if (arg < setpoint_q) begin
          action_d = ACT_ON;
        end else if (arg > setpoint_q) begin
          action_d = ACT_OFF;
        end
      end else if (cmd == CMD_DEFROST) begin
        status_d = ST_DEFROST;
      end else if (cmd == CMD_WORK) begin
        status_d = ST_WORK;
      end else if (cmd == CMD_REST) begin
        status_d = ST_REST;
      end else if (cmd == CMD_LED) begin
        status_d = ST_LED;
      end else begin
        status_d = ST_UNKNOWN;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= 1'b0;
      setpoint_q <= SETPOINT_RESET;
    end else begin
      if (fire) begin
        valid_q    <= 1'b1;
        setpoint_q <= setpoint_d;
      end else if (res_ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      status_q  <= status_d;
      value_q   <= value_d;
      nonzero_q <= (value_d != 8'd0);
      action_q  <= action_d;
    end
  end

  assign res_valid_o     = valid_q;
  assign status_o        = status_q;
  assign value_o         = value_q;
  assign value_nonzero_o = nonzero_q;
  assign setpoint_o      = setpoint_q;
  assign action_o        = action_q;

  a_bad_frame_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && (status_q == ST_BAD) |-> (value_q == 8'd0) && (action_q == ACT_NONE))
    else $error("bad frame result carries data");

  a_action_only_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && (action_q != ACT_NONE) |-> (status_q == ST_SET_TEMP))
    else $error("cooler action without set temperature");

  a_setpoint_on_fire: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(setpoint_q) |-> $past(fire) && (status_q == ST_SET_TEMP))
    else $error("setpoint moved outside a set temperature frame");

  a_nonzero_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> (nonzero_q == (value_q != 8'd0)))
    else $error("value_nonzero disagrees with value");

endmodule
